[src/wros_pkg.sv]
package wros_pkg;

  localparam int MAX_NODES   = 64;
  localparam int NUM_CLASSES = 5;
  localparam int POS_W       = $clog2(MAX_NODES + 1);
  localparam int INDEX_W     = 6;
  localparam int CHI2_W      = 24;
  localparam int LIMIT_W     = 25;
  localparam int COUNT_W     = 7;
  localparam int KIND_W      = 4;
  localparam int CLS_W       = $clog2(NUM_CLASSES + 1);
  localparam int SCAN_W      = $clog2(NUM_CLASSES);
  localparam int CFG_IDX_W   = 3;
  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CHI2_LIMIT    = 3'd0;
  localparam int                   REG_MIN_HITS_BASE = 1;

  typedef logic [CLS_W-1:0]   class_t;
  typedef logic [CHI2_W-1:0]  chi2_t;
  typedef logic [INDEX_W-1:0] index_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [POS_W-1:0]   pos_t;
  typedef count_t [NUM_CLASSES-1:0] min_hits_t;

  localparam class_t CLS_NONE = class_t'(NUM_CLASSES);
  localparam count_t COUNT_MAX = {COUNT_W{1'b1}};

  // measurement kind -> hit class
  localparam class_t KIND_CLASS [2**KIND_W] = '{
    CLS_NONE, class_t'(0), class_t'(1), class_t'(0), class_t'(1), class_t'(2),
    class_t'(3), class_t'(3), class_t'(4), class_t'(2), class_t'(3),
    CLS_NONE, CLS_NONE, CLS_NONE, CLS_NONE, CLS_NONE
  };

  // classified node as handed from front to back
  typedef struct packed {
    logic   counted;  // hit on track, known class, within MAX_NODES
    logic   meas;
    class_t cls;
    chi2_t  chi2;
    index_t pos;
    logic   last;
  } node_t;

  typedef struct packed {
    logic   removal;
    logic   marked;
    index_t index;
  } result_t;

endpackage

[src/wros_front.sv]
module wros_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic                          in_is_hit_on_track,
  input  logic                          in_has_measurement,
  input  logic [wros_pkg::KIND_W-1:0]   in_measurement_kind,
  input  logic [wros_pkg::CHI2_W-1:0]   in_node_chi2,
  input  logic                          in_last_node,
  input  logic                          q_full,
  output logic                          q_push,
  output wros_pkg::node_t               q_node
);
  import wros_pkg::*;

  pos_t   pos_r;
  class_t cls;
  logic   in_range;

  assign in_full  = q_full;
  assign q_push   = in_push && !q_full;
  assign cls      = KIND_CLASS[in_measurement_kind];
  assign in_range = (pos_r < pos_t'(MAX_NODES));

  always_comb begin
    q_node.counted = in_is_hit_on_track && (cls != CLS_NONE) && in_range;
    q_node.meas    = in_has_measurement;
    q_node.cls     = cls;
    q_node.chi2    = in_node_chi2;
    q_node.pos     = index_t'(pos_r);
    q_node.last    = in_last_node;
  end

  // node position, saturating at MAX_NODES, restarted after the last node
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (q_push) begin
      if (in_last_node) begin
        pos_r <= '0;
      end else if (in_range) begin
        pos_r <= pos_r + pos_t'(1);
      end
    end
  end

endmodule

[src/wros_node_q.sv]
module wros_node_q (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  wros_pkg::node_t push_node,
  output logic            full,
  input  logic            pop,
  output wros_pkg::node_t pop_node,
  output logic            empty
);
  import wros_pkg::*;

  node_t                mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r;
  logic [Q_PTR_W-1:0]   rd_ptr_r;
  logic [Q_CNT_W-1:0]   cnt_r;
  logic                 do_push;
  logic                 do_pop;

  assign full     = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_node = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_node;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - Q_CNT_W'(1);
      end
    end
  end

endmodule

[src/wros_back.sv]
module wros_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_empty,
  input  wros_pkg::node_t                    q_node,
  output logic                               q_pop,
  input  logic signed [wros_pkg::LIMIT_W-1:0] chi2_limit,
  input  wros_pkg::min_hits_t                min_hits,
  output logic                               out_valid,
  input  logic                               out_pop,
  output wros_pkg::result_t                  out_result
);
  import wros_pkg::*;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_SCAN,
    ST_EMIT
  } state_t;

  state_t              state_r;
  count_t              cnt_r       [NUM_CLASSES];
  chi2_t               best_chi2_r [NUM_CLASSES];
  index_t              best_idx_r  [NUM_CLASSES];
  logic                valid_r     [NUM_CLASSES];
  logic [SCAN_W-1:0]   scan_r;
  logic                found_r;
  chi2_t               pick_chi2_r;
  index_t              pick_idx_r;
  logic                out_valid_r;
  result_t             out_result_r;

  logic                limit_neg;
  logic                above_limit;
  logic                eligible;
  logic                better;

  assign limit_neg   = chi2_limit[LIMIT_W-1];
  assign above_limit = (q_node.chi2 > chi2_limit[CHI2_W-1:0]);
  assign q_pop       = (state_r == ST_RUN) && !q_empty;
  assign out_valid   = out_valid_r;
  assign out_result  = out_result_r;

  // one class per scan step
  assign eligible = valid_r[scan_r] && (cnt_r[scan_r] > min_hits[scan_r]);
  assign better   = !found_r || (best_chi2_r[scan_r] > pick_chi2_r) ||
                    ((best_chi2_r[scan_r] == pick_chi2_r) && (best_idx_r[scan_r] < pick_idx_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      out_valid_r <= 1'b0;
      scan_r      <= '0;
      found_r     <= 1'b0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        cnt_r[c]       <= '0;
        best_chi2_r[c] <= '0;
        best_idx_r[c]  <= '0;
        valid_r[c]     <= 1'b0;
      end
    end else begin
      if (out_pop && out_valid_r) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_RUN: begin
          if (!q_empty) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
              if (q_node.counted && (q_node.cls == class_t'(c))) begin
                if (cnt_r[c] != COUNT_MAX) begin
                  cnt_r[c] <= cnt_r[c] + count_t'(1);
                end
                if (q_node.meas && !limit_neg && above_limit &&
                    (!valid_r[c] || (q_node.chi2 > best_chi2_r[c]))) begin
                  valid_r[c]     <= 1'b1;
                  best_chi2_r[c] <= q_node.chi2;
                  best_idx_r[c]  <= q_node.pos;
                end
              end
            end
            if (q_node.last) begin
              state_r <= ST_SCAN;
              scan_r  <= '0;
              found_r <= 1'b0;
            end
          end
        end
        ST_SCAN: begin
          if (eligible && better) begin
            found_r     <= 1'b1;
            pick_chi2_r <= best_chi2_r[scan_r];
            pick_idx_r  <= best_idx_r[scan_r];
          end
          if (scan_r == SCAN_W'(NUM_CLASSES - 1)) begin
            state_r <= ST_EMIT;
          end else begin
            scan_r <= scan_r + SCAN_W'(1);
          end
        end
        ST_EMIT: begin
          if (!out_valid_r || out_pop) begin
            out_valid_r          <= 1'b1;
            out_result_r.removal <= limit_neg || found_r;
            out_result_r.marked  <= !limit_neg && found_r;
            out_result_r.index   <= (!limit_neg && found_r) ? pick_idx_r : '0;
            for (int c = 0; c < NUM_CLASSES; c++) begin
              cnt_r[c]       <= '0;
              best_chi2_r[c] <= '0;
              valid_r[c]     <= 1'b0;
            end
            state_r <= ST_RUN;
          end
        end
        default: begin
          state_r <= ST_RUN;
        end
      endcase
    end
  end

endmodule

[src/worst_residual_outlier_select.sv]
// Worst-residual outlier select.
// Input channel (in_*): one track node per word, pushed while in_full is low.
//   The final node of a track carries in_last_node.
// Result channel (out_*): one word per track, valid while out_empty is low,
//   taken with out_pop. It names the node to turn into an outlier, if any.
// Config channel (cfg_*): register writes, cfg_ready is always high.
//   Index 0 is the signed Q16.8 chi-square limit, 1..5 the per-class minimum
//   hit counts. Indexes past 5 are dropped. Write only while idle.
// Throughput: one node per cycle, set by the back end's per-class update,
//   while the back end runs. After a track's last node the back end scans
//   the 5 classes (one class a cycle) and then loads the result before the
//   next track's nodes update; meanwhile the 2-deep node queue keeps taking
//   words.
// Reset: synchronous, rst_n low. Queues empty, counts cleared, registers at
//   their reset values (limit 9.0, minimums 2,2,2,4,4).
// Stall: a result not popped holds the back end in its load step; the node
//   queue then fills and in_full rises.
module worst_residual_outlier_select (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_push,
  output logic                                  in_full,
  input  logic                                  in_is_hit_on_track,
  input  logic                                  in_has_measurement,
  input  logic [wros_pkg::KIND_W-1:0]           in_measurement_kind,
  input  logic [wros_pkg::CHI2_W-1:0]           in_node_chi2,
  input  logic                                  in_last_node,
  output logic                                  out_empty,
  input  logic                                  out_pop,
  output logic                                  out_removal_reported,
  output logic                                  out_node_marked,
  output logic [wros_pkg::INDEX_W-1:0]          out_node_index,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [wros_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic signed [wros_pkg::LIMIT_W-1:0]   cfg_data
);
  import wros_pkg::*;

  logic signed [LIMIT_W-1:0] chi2_limit_r;
  min_hits_t                 min_hits_r;

  logic    q_full;
  logic    q_push;
  node_t   q_in_node;
  logic    q_empty;
  logic    q_pop;
  node_t   q_out_node;
  logic    res_valid;
  result_t res;

  assign cfg_ready = 1'b1;

  // config register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chi2_limit_r  <= LIMIT_W'(2304);
      min_hits_r[0] <= count_t'(2);
      min_hits_r[1] <= count_t'(2);
      min_hits_r[2] <= count_t'(2);
      min_hits_r[3] <= count_t'(4);
      min_hits_r[4] <= count_t'(4);
    end else if (cfg_valid) begin
      if (cfg_index == REG_CHI2_LIMIT) begin
        chi2_limit_r <= cfg_data;
      end
      for (int c = 0; c < NUM_CLASSES; c++) begin
        if (cfg_index == CFG_IDX_W'(REG_MIN_HITS_BASE + c)) begin
          min_hits_r[c] <= cfg_data[COUNT_W-1:0];
        end
      end
    end
  end

  wros_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_is_hit_on_track  (in_is_hit_on_track),
    .in_has_measurement  (in_has_measurement),
    .in_measurement_kind (in_measurement_kind),
    .in_node_chi2        (in_node_chi2),
    .in_last_node        (in_last_node),
    .q_full              (q_full),
    .q_push              (q_push),
    .q_node              (q_in_node)
  );

  wros_node_q u_node_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_node (q_in_node),
    .full      (q_full),
    .pop       (q_pop),
    .pop_node  (q_out_node),
    .empty     (q_empty)
  );

  wros_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_node     (q_out_node),
    .q_pop      (q_pop),
    .chi2_limit (chi2_limit_r),
    .min_hits   (min_hits_r),
    .out_valid  (res_valid),
    .out_pop    (out_pop),
    .out_result (res)
  );

  assign out_empty            = !res_valid;
  assign out_removal_reported = res.removal;
  assign out_node_marked      = res.marked;
  assign out_node_index       = res.index;

endmodule

[src/wros_checker.sv]
module wros_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 out_empty,
  input logic                                 out_pop,
  input logic                                 out_removal_reported,
  input logic                                 out_node_marked,
  input logic [wros_pkg::INDEX_W-1:0]         out_node_index
);
  import wros_pkg::*;

  // nothing to deliver right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result word present after reset");

  // a waiting result word holds until popped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_removal_reported) &&
      $stable(out_node_marked) && $stable(out_node_index)))
    else $error("result word changed or vanished before pop");

  // a marked node always comes with a removal
  a_mark_removal: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_node_marked) |-> out_removal_reported)
    else $error("node marked without removal");

  // no index without a marked node
  a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_node_marked) |-> (out_node_index == '0))
    else $error("index set on an unmarked result");

endmodule

bind worst_residual_outlier_select wros_checker u_wros_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_empty            (out_empty),
  .out_pop              (out_pop),
  .out_removal_reported (out_removal_reported),
  .out_node_marked      (out_node_marked),
  .out_node_index       (out_node_index)
);
